// ===== hdl/si_pkg.sv =====
// Package for the segment intersection block: widths, payload words and
// pipeline structs. No dependencies.
`default_nettype none
package si_pkg;
    localparam int CW  = 16;               // coordinate width
    localparam int FB  = 16;               // fraction bits of t
    localparam int DFW = CW + 1;           // coordinate difference
    localparam int PW  = 2 * DFW;          // product of two differences
    localparam int XW  = PW + 1;           // cross product
    localparam int DW  = XW - 1;           // normalized magnitude
    localparam int QW  = ((CW > FB) ? CW : FB) + 1;  // quotient bits
    localparam int NW  = DW + QW;          // division numerator
    localparam int NSTAGE_X = 5;           // difference/product/cross/normalize/multiply stages
    localparam int NSTAGE   = NSTAGE_X + QW + 1;

    typedef struct packed {
        logic signed [CW-1:0] ax;
        logic signed [CW-1:0] ay;
        logic signed [CW-1:0] bx;
        logic signed [CW-1:0] by;
        logic signed [CW-1:0] cx;
        logic signed [CW-1:0] cy;
        logic signed [CW-1:0] dx;
        logic signed [CW-1:0] dy;
    } t_seg_in;

    typedef struct packed {
        logic                 hit;
        logic [FB:0]          t_fraction;
        logic signed [CW-1:0] hit_x;
        logic signed [CW-1:0] hit_y;
    } t_seg_out;

    typedef struct packed {
        logic                 hit;
        logic                 negx;
        logic                 negy;
        logic signed [CW-1:0] ax;
        logic signed [CW-1:0] ay;
    } t_side;

    typedef struct packed {
        t_side          side;
        logic [DW-1:0]  bot;
        logic [NW-1:0]  nx;
        logic [NW-1:0]  ny;
        logic [NW-1:0]  nf;
        logic [QW-1:0]  qx;
        logic [QW-1:0]  qy;
        logic [QW-1:0]  qf;
    } t_div;
endpackage
`default_nettype wire

// ===== hdl/si_cross.sv =====
// Differences, cross products, sign normalization, range test and numerator
// products. Depends on si_pkg.
`default_nettype none
module si_cross (
    input  wire logic                      i_clk,
    input  wire logic [si_pkg::NSTAGE_X-1:0] i_en,
    input  wire si_pkg::t_seg_in           i_data,
    output si_pkg::t_div                   o_data
);
    import si_pkg::*;

    logic signed [DFW-1:0] r_dxc, r_dyc, r_axc, r_ayc, r_bax, r_bay;
    logic signed [CW-1:0]  r_ax0, r_ay0, r_ax1, r_ay1, r_ax2, r_ay2;
    logic signed [PW-1:0]  r_p0, r_p1, r_p2, r_p3, r_p4, r_p5;
    logic signed [DFW-1:0] r_bax1, r_bay1, r_bax2, r_bay2;
    logic signed [XW-1:0]  r_tt, r_ut, r_bt;
    t_side                 r_side;
    logic [DW-1:0]         r_tn, r_bn;
    logic [CW-1:0]         r_mx, r_my;
    t_div                  r_out;

    logic signed [XW-1:0]  tn, un, bn;
    logic signed [DFW-1:0] nbx, nby;
    logic                  hit;

    always_comb begin
        tn  = r_bt[XW-1] ? -r_tt : r_tt;
        un  = r_bt[XW-1] ? -r_ut : r_ut;
        bn  = r_bt[XW-1] ? -r_bt : r_bt;
        hit = (r_bt != '0) && !tn[XW-1] && !un[XW-1] && (tn <= bn) && (un <= bn);
        nbx = -r_bax2;
        nby = -r_bay2;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_dxc <= DFW'(i_data.dx) - DFW'(i_data.cx);
            r_dyc <= DFW'(i_data.dy) - DFW'(i_data.cy);
            r_axc <= DFW'(i_data.ax) - DFW'(i_data.cx);
            r_ayc <= DFW'(i_data.ay) - DFW'(i_data.cy);
            r_bax <= DFW'(i_data.bx) - DFW'(i_data.ax);
            r_bay <= DFW'(i_data.by) - DFW'(i_data.ay);
            r_ax0 <= i_data.ax;
            r_ay0 <= i_data.ay;
        end
        if (i_en[1]) begin
            r_p0   <= r_dxc * r_ayc;
            r_p1   <= r_dyc * r_axc;
            r_p2   <= r_ayc * r_bax;
            r_p3   <= r_axc * r_bay;
            r_p4   <= r_dyc * r_bax;
            r_p5   <= r_dxc * r_bay;
            r_bax1 <= r_bax;
            r_bay1 <= r_bay;
            r_ax1  <= r_ax0;
            r_ay1  <= r_ay0;
        end
        if (i_en[2]) begin
            r_tt   <= XW'(r_p0) - XW'(r_p1);
            r_ut   <= XW'(r_p2) - XW'(r_p3);
            r_bt   <= XW'(r_p4) - XW'(r_p5);
            r_bax2 <= r_bax1;
            r_bay2 <= r_bay1;
            r_ax2  <= r_ax1;
            r_ay2  <= r_ay1;
        end
        if (i_en[3]) begin
            r_side.hit  <= hit;
            r_side.negx <= r_bax2[DFW-1];
            r_side.negy <= r_bay2[DFW-1];
            r_side.ax   <= r_ax2;
            r_side.ay   <= r_ay2;
            r_tn <= tn[DW-1:0];
            r_bn <= bn[DW-1:0];
            r_mx <= r_bax2[DFW-1] ? nbx[CW-1:0] : r_bax2[CW-1:0];
            r_my <= r_bay2[DFW-1] ? nby[CW-1:0] : r_bay2[CW-1:0];
        end
        if (i_en[4]) begin
            r_out.side <= r_side;
            r_out.bot  <= r_bn;
            r_out.nx   <= NW'(r_mx) * NW'(r_tn);
            r_out.ny   <= NW'(r_my) * NW'(r_tn);
            r_out.nf   <= NW'(r_tn) << FB;
            r_out.qx   <= '0;
            r_out.qy   <= '0;
            r_out.qf   <= '0;
        end
    end

    assign o_data = r_out;
endmodule
`default_nettype wire

// ===== hdl/si_div.sv =====
// Restoring division pipeline, one quotient bit per stage, three lanes
// sharing one divisor. Depends on si_pkg.
`default_nettype none
module si_div (
    input  wire logic                i_clk,
    input  wire logic [si_pkg::QW-1:0] i_en,
    input  wire si_pkg::t_div        i_data,
    output si_pkg::t_div             o_data
);
    import si_pkg::*;

    t_div r_st [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        localparam int B = QW - 1 - k;
        t_div          cur;
        t_div          n_st;
        logic [NW-1:0] sh;

        assign cur = (k == 0) ? i_data : r_st[(k == 0) ? 0 : k - 1];

        always_comb begin
            sh   = NW'(cur.bot) << B;
            n_st = cur;
            if (cur.nx >= sh) begin
                n_st.nx    = cur.nx - sh;
                n_st.qx[B] = 1'b1;
            end
            if (cur.ny >= sh) begin
                n_st.ny    = cur.ny - sh;
                n_st.qy[B] = 1'b1;
            end
            if (cur.nf >= sh) begin
                n_st.nf    = cur.nf - sh;
                n_st.qf[B] = 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en[k]) begin
                r_st[k] <= n_st;
            end
        end
    end

    assign o_data = r_st[QW-1];
endmodule
`default_nettype wire

// ===== hdl/si_out.sv =====
// Output stage: apply sign to the scaled deltas, add the start point, zero
// fields on a miss. Depends on si_pkg.
`default_nettype none
module si_out (
    input  wire logic          i_clk,
    input  wire logic          i_en,
    input  wire si_pkg::t_div  i_data,
    output si_pkg::t_seg_out   o_data
);
    import si_pkg::*;

    localparam int SW = QW + 1;

    t_seg_out          r_out;
    logic signed [SW-1:0] dx, dy, sx, sy;

    always_comb begin
        dx = $signed({1'b0, i_data.qx});
        dy = $signed({1'b0, i_data.qy});
        sx = SW'(i_data.side.ax) + (i_data.side.negx ? -dx : dx);
        sy = SW'(i_data.side.ay) + (i_data.side.negy ? -dy : dy);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out.hit        <= i_data.side.hit;
            r_out.t_fraction <= i_data.side.hit ? i_data.qf[FB:0] : '0;
            r_out.hit_x      <= i_data.side.hit ? sx[CW-1:0] : '0;
            r_out.hit_y      <= i_data.side.hit ? sy[CW-1:0] : '0;
        end
    end

    assign o_data = r_out;
endmodule
`default_nettype wire

// ===== hdl/segment_intersection_top.sv =====
// Segment intersection top: cross stages, divider stages and an output stage in
// order; one word accepted per cycle when the output is taken every cycle.
// Most of the depth is the divider, one quotient bit per stage.
// Each stage advances when empty or when the next stage advances, so bubbles
// close up under an output stall. Reset clears the stage valid bits only.
`default_nettype none
module segment_intersection_top (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire si_pkg::t_seg_in   i_in_data,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output si_pkg::t_seg_out       o_out_data
);
    import si_pkg::*;

    logic [NSTAGE-1:0] r_v;
    logic [NSTAGE:0]   en;
    t_div              x2d, d2o;

    always_comb begin
        en[NSTAGE] = i_out_ready;
        for (int k = NSTAGE - 1; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < NSTAGE; k++) begin
                if (en[k]) begin
                    r_v[k] <= (k == 0) ? i_in_valid : r_v[(k == 0) ? 0 : k - 1];
                end
            end
        end
    end

    si_cross u_cross (
        .i_clk  (i_clk),
        .i_en   (en[NSTAGE_X-1:0]),
        .i_data (i_in_data),
        .o_data (x2d)
    );

    si_div u_div (
        .i_clk  (i_clk),
        .i_en   (en[NSTAGE_X+QW-1:NSTAGE_X]),
        .i_data (x2d),
        .o_data (d2o)
    );

    si_out u_out (
        .i_clk  (i_clk),
        .i_en   (en[NSTAGE-1]),
        .i_data (d2o),
        .o_data (o_out_data)
    );

    assign o_in_ready  = en[0];
    assign o_out_valid = r_v[NSTAGE-1];

`ifndef SYNTHESIS
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.hit |-> o_out_data.t_fraction == '0 &&
            o_out_data.hit_x == '0 && o_out_data.hit_y == '0)
        else $error("miss with nonzero fields");
    a_frac_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.hit |->
            o_out_data.t_fraction <= ((FB+1)'(1) << FB))
        else $error("t fraction above one");
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_v[0] |-> o_in_ready)
        else $error("empty first stage not ready");
`endif
endmodule
`default_nettype wire

// ===== tb/sv/segment_intersection_top_tb.sv =====
// Testbench for segment_intersection_top: drives segment pairs, predicts hit,
// t fraction and hit point, and checks every result word in order.
// Depends on si_pkg and segment_intersection_top.
`default_nettype none
module segment_intersection_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import si_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 60;

    logic     i_clk = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     i_in_valid = 1'b0;
    logic     o_in_ready;
    t_seg_in  i_in_data = '0;
    logic     o_out_valid;
    logic     i_out_ready = 1'b0;
    t_seg_out o_out_data;

    t_seg_out expected_hits[$];
    int       mismatch_count = 0;
    int       idle_cycles = 0;
    bit       timed_out = 1'b0;
    int       burst_left = 0;
    bit       stall_mode = 1'b0;

    segment_intersection_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data)
    );

    always #2 i_clk = ~i_clk;

    function automatic longint unsigned div_by_bits(longint unsigned num,
                                                    longint unsigned den);
        return num / den;
    endfunction

    function automatic t_seg_out predict_intersection(t_seg_in s);
        longint ax, ay, bx, by, cx, cy, dx, dy;
        longint t_top, u_top, bottom, hx, hy;
        longint unsigned tt, bot;
        t_seg_out r;
        ax = s.ax; ay = s.ay; bx = s.bx; by = s.by;
        cx = s.cx; cy = s.cy; dx = s.dx; dy = s.dy;
        r = '0;
        t_top  = (dx - cx) * (ay - cy) - (dy - cy) * (ax - cx);
        u_top  = (cy - ay) * (ax - bx) - (cx - ax) * (ay - by);
        bottom = (dy - cy) * (bx - ax) - (dx - cx) * (by - ay);
        if (bottom == 0) return r;
        if (bottom < 0) begin
            bottom = -bottom; t_top = -t_top; u_top = -u_top;
        end
        if (t_top < 0 || t_top > bottom || u_top < 0 || u_top > bottom) return r;
        tt = t_top;
        bot = bottom;
        // products stay below 2^53, so the quotients are exact in 64 bits
        hx = (bx - ax) * t_top / bottom;
        hy = (by - ay) * t_top / bottom;
        r.hit = 1'b1;
        r.t_fraction = (FB+1)'(div_by_bits(tt << FB, bot));
        r.hit_x = CW'(ax + hx);
        r.hit_y = CW'(ay + hy);
        return r;
    endfunction

    // receiver stall pattern: alternate free runs and stalls
    always @(posedge i_clk) begin
        if ($urandom_range(0, 31) == 0) stall_mode <= ~stall_mode;
        i_out_ready <= stall_mode ? ($urandom_range(0, 3) == 0) : ($urandom_range(0, 7) != 0);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_hits.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) $display("unexpected word %p", o_out_data);
            end else begin
                t_seg_out e;
                e = expected_hits.pop_front();
                if (e.hit !== o_out_data.hit || e.t_fraction !== o_out_data.t_fraction ||
                    e.hit_x !== o_out_data.hit_x || e.hit_y !== o_out_data.hit_y) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"mismatch: exp hit=%0d t=%0d x=%0d y=%0d ",
                                  "got hit=%0d t=%0d x=%0d y=%0d"},
                                 e.hit, e.t_fraction, e.hit_x, e.hit_y, o_out_data.hit,
                                 o_out_data.t_fraction, o_out_data.hit_x, o_out_data.hit_y);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
            timed_out = 1'b1;
            $display("Verification failed");
            $finish;
        end
    end

    task automatic send_word(t_seg_in s);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_in_data  <= s;
        expected_hits.push_back(predict_intersection(s));
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    function automatic t_seg_in make_pair(int ax, int ay, int bx, int by,
                                          int cx, int cy, int dx, int dy);
        t_seg_in s;
        s.ax = CW'(ax); s.ay = CW'(ay); s.bx = CW'(bx); s.by = CW'(by);
        s.cx = CW'(cx); s.cy = CW'(cy); s.dx = CW'(dx); s.dy = CW'(dy);
        return s;
    endfunction

    function automatic logic signed [CW-1:0] rand_coord(int span);
        if (span == 0) return CW'($urandom);
        return CW'($signed($urandom_range(0, 2 * span)) - span);
    endfunction

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (expected_hits.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed();
        send_word(make_pair(0, 0, 10, 10, 0, 10, 10, 0));
        send_word(make_pair(0, 0, 10, 0, 0, 5, 10, 5));
        send_word(make_pair(0, 0, 10, 0, 2, 0, 8, 0));
        send_word(make_pair(3, 3, 3, 3, 0, 0, 9, 9));
        send_word(make_pair(0, 0, 10, 0, 0, -5, 0, 5));
        send_word(make_pair(0, 0, 10, 0, 10, -5, 10, 5));
        send_word(make_pair(0, 0, 10, 0, 5, 0, 5, 5));
        send_word(make_pair(0, 0, 10, 0, 11, -5, 11, 5));
        send_word(make_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
        send_word(make_pair(32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767));
        send_word(make_pair(-32768, 0, 32767, 0, 0, -32768, 1, 32767));
        send_word(make_pair(-32768, -32768, -32768, 32767, 32767, 0, -32768, 1));
        send_word(make_pair(0, 0, 3, 7, 3, 0, 0, 7));
        send_word(make_pair(-1, -1, -1, -1, -1, -1, -1, -1));
        send_word(make_pair(32767, 32767, -32768, -32768, 32767, -32768, -32768, 32767));
        send_word(make_pair(0, 0, 7, 0, 1, 1, 2, -3));
    endtask

    task automatic test_pause_until_drained();
        wait_drained();
        send_word(make_pair(0, 0, 100, 50, 0, 50, 100, 0));
        wait_drained();
    endtask

    task automatic test_random_crossings(int count);
        t_seg_in s;
        int span;
        logic signed [CW-1:0] mx, my;
        for (int n = 0; n < count; n++) begin
            span = ($urandom_range(0, 3) == 0) ? 0 : ($urandom_range(0, 1) ? 100 : 32767);
            s = make_pair(rand_coord(span), rand_coord(span), rand_coord(span),
                          rand_coord(span), rand_coord(span), rand_coord(span),
                          rand_coord(span), rand_coord(span));
            case ($urandom_range(0, 9)) inside
                [0:4]: begin
                    // place C and D on opposite sides of AB's midpoint
                    mx = CW'((s.ax + s.bx) / 2);
                    my = CW'((s.ay + s.by) / 2);
                    s.cx = mx + rand_coord(50);
                    s.cy = my + rand_coord(50);
                    s.dx = mx - (s.cx - mx);
                    s.dy = my - (s.cy - my);
                end
                5: begin
                    s.cx = s.ax; s.cy = s.ay;
                end
                6: begin
                    s.dx = s.cx + (s.bx - s.ax); s.dy = s.cy + (s.by - s.ay);
                end
                default: ;
            endcase
            send_word(s);
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_pause_until_drained();
        test_random_crossings(1100);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && expected_hits.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
`default_nettype wire
